@@ design/wced_pkg.sv @@
// shared constants, types and codes of the 3x3 window filter
`timescale 1ns / 1ps
`default_nettype none

package wced_pkg;

  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;

  localparam int COL_W     = $clog2(IMAGE_WIDTH);
  localparam int ROW_W     = $clog2(IMAGE_HEIGHT);
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 16;
  localparam int PSUM_W    = PROD_W + 2;
  localparam int SUM_W     = PROD_W + 4;

  localparam logic [CFG_W-1:0] KERNEL_RESET = 24'h010101;

  typedef enum logic [1:0] {
    MODE_CONV   = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_DILATE = 2'd2,
    MODE_ZERO   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_TOP    = 4'd0,
    REG_KERNEL_MID    = 4'd1,
    REG_KERNEL_BOTTOM = 4'd2,
    REG_OP_MODE       = 4'd3
  } reg_idx_e;

  typedef struct packed {
    logic       keep;
    logic       strb;
    logic [1:0] user;
    logic       last;
    logic [5:0] dest;
  } side_t;

  typedef logic [PIX_W-1:0] pix_t;
  // index 0 is the top (oldest) row
  typedef pix_t [2:0] colv_t;
  // index 0 is the oldest column
  typedef colv_t [2:0] win_t;
  typedef logic [CFG_W-1:0] krow_t;
  // index 0 is the top row
  typedef krow_t [2:0] kernel_t;

endpackage

`default_nettype wire

@@ design/window_3x3_conv_erode_dilate.sv @@
// top level of the 3x3 convolution, erode and dilate window filter
`timescale 1ns / 1ps
`default_nettype none

// Raster-order 8-bit pixel filter over a 3x3 window, one item per clock while
// the output is not stalled; the result is registered in stages s1, s2, a, b and
// c. The two rows above the current one live in a single line RAM of IMAGE_WIDTH
// x 16 bits, read at the current column as the item is taken and written back as
// it leaves s1, so the one read and one write port of that RAM set the rate. The
// RAM needs no clearing after reset: the first two rows and columns of each
// frame are borders and give 0. Stall on the output backs up through the
// pipeline registers to in_stall_o; empty stages still take new items. The user
// must write configuration (kernel rows and op_mode) through cfg_we_i, cfg_idx_i
// and cfg_data_i only while the block is idle; the block does not enforce it.
module window_3x3_conv_erode_dilate import wced_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           pixel_in_i,
  input  wire logic                 keep_in_i,
  input  wire logic                 strb_in_i,
  input  wire logic [1:0]           user_in_i,
  input  wire logic                 last_in_i,
  input  wire logic [5:0]           dest_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                pixel_out_o,
  output logic                      keep_out_o,
  output logic                      strb_out_o,
  output logic [1:0]                user_out_o,
  output logic                      last_out_o,
  output logic [5:0]                dest_out_o
);

  kernel_t kernel_q, kernel_d;
  mode_e   mode_q, mode_d;

  side_t side_in, win_side, side_out;
  win_t  win;
  logic  win_valid, win_stall, win_active;

  always_comb begin
    kernel_d = kernel_q;
    mode_d   = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KERNEL_TOP:    kernel_d[0] = cfg_data_i;
        REG_KERNEL_MID:    kernel_d[1] = cfg_data_i;
        REG_KERNEL_BOTTOM: kernel_d[2] = cfg_data_i;
        REG_OP_MODE:       mode_d      = mode_e'(cfg_data_i[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= {KERNEL_RESET, KERNEL_RESET, KERNEL_RESET};
      mode_q   <= MODE_CONV;
    end else begin
      kernel_q <= kernel_d;
      mode_q   <= mode_d;
    end
  end

  assign side_in = '{keep: keep_in_i, strb: strb_in_i, user: user_in_i,
                     last: last_in_i, dest: dest_in_i};

  wced_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_in_i),
    .side_i      (side_in),
    .win_valid_o (win_valid),
    .win_stall_i (win_stall),
    .win_o       (win),
    .side_o      (win_side),
    .active_o    (win_active)
  );

  wced_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_stall_o (win_stall),
    .win_i       (win),
    .side_i      (win_side),
    .active_i    (win_active),
    .kernel_i    (kernel_q),
    .mode_i      (mode_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_o     (pixel_out_o),
    .side_o      (side_out)
  );

  assign keep_out_o = side_out.keep;
  assign strb_out_o = side_out.strb;
  assign user_out_o = side_out.user;
  assign last_out_o = side_out.last;
  assign dest_out_o = side_out.dest;

endmodule

`default_nettype wire

@@ design/wced_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wced_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 640,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/wced_window.sv @@
// raster counters, two-row line store and 3x3 window assembly
`timescale 1ns / 1ps
`default_nettype none

module wced_window import wced_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire pix_t  pixel_i,
  input  wire side_t side_i,
  output logic       win_valid_o,
  input  wire logic  win_stall_i,
  output win_t       win_o,
  output side_t      side_o,
  output logic       active_o
);

  logic             accept;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             s1_valid_q, s1_valid_d;
  pix_t             s1_pix_q;
  side_t            s1_side_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_act_q;
  logic             s1_adv;

  logic             s2_valid_q, s2_valid_d;
  win_t             win_q;
  side_t            s2_side_q;
  logic             s2_act_q;
  logic             s2_adv;

  colv_t            hist_q [2];
  colv_t            cur;
  logic [2*PIX_W-1:0] rd_data;

  assign s2_adv     = s2_valid_q && !win_stall_i;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // each entry holds the two rows above the current one at that column
  wced_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (IMAGE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({rd_data[PIX_W-1:0], s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    cur[0] = rd_data[2*PIX_W-1:PIX_W];
    cur[1] = rd_data[PIX_W-1:0];
    cur[2] = s1_pix_q;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == COL_W'(IMAGE_WIDTH - 1)) begin
        col_d = '0;
        if (row_q == ROW_W'(IMAGE_HEIGHT - 1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    s2_valid_d = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_side_q <= side_i;
      s1_col_q  <= col_q;
      s1_act_q  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
    end
    if (s1_adv) begin
      // history across a row end is stale but those pixels are borders
      hist_q[0] <= hist_q[1];
      hist_q[1] <= cur;
      win_q[0]  <= hist_q[0];
      win_q[1]  <= hist_q[1];
      win_q[2]  <= cur;
      s2_side_q <= s1_side_q;
      s2_act_q  <= s1_act_q;
    end
  end

  assign win_valid_o = s2_valid_q;
  assign win_o       = win_q;
  assign side_o      = s2_side_q;
  assign active_o    = s2_act_q;

endmodule

`default_nettype wire

@@ design/wced_arith.sv @@
// kernel products, reduction and output selection
`timescale 1ns / 1ps
`default_nettype none

module wced_arith import wced_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    win_valid_i,
  output logic         win_stall_o,
  input  wire win_t    win_i,
  input  wire side_t   side_i,
  input  wire logic    active_i,
  input  wire kernel_t kernel_i,
  input  wire mode_e   mode_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pix_t         pixel_o,
  output side_t        side_o
);

  logic a_valid_q, a_valid_d, a_adv;
  logic b_valid_q, b_valid_d, b_adv;
  logic c_valid_q, c_valid_d, c_adv;
  logic win_accept;

  logic signed [PROD_W-1:0] prod_q [9];
  side_t                    a_side_q, b_side_q, c_side_q;
  logic                     a_act_q, b_act_q;

  logic signed [PSUM_W-1:0] psum_q [3];
  pix_t                     pmin_q [3];
  pix_t                     pmax_q [3];

  pix_t                     pixel_q, pixel_d;

  logic signed [PROD_W:0]   prod_full [9];
  logic signed [PSUM_W-1:0] psum_d [3];
  pix_t                     pmin_d [3];
  pix_t                     pmax_d [3];
  logic signed [SUM_W-1:0]  total;
  logic [SUM_W-4:0]         quot;
  pix_t                     mn, mx;

  assign c_adv       = c_valid_q && !out_stall_i;
  assign b_adv       = b_valid_q && (!c_valid_q || c_adv);
  assign a_adv       = a_valid_q && (!b_valid_q || b_adv);
  assign win_stall_o = a_valid_q && !a_adv;
  assign win_accept  = win_valid_i && !win_stall_o;

  // signed coefficient times unsigned pixel, fits in PROD_W bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_full[3*r+c] = $signed(kernel_i[r][8*c +: 8]) *
                           $signed({1'b0, win_i[c][r]});
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      psum_d[g] = PSUM_W'(prod_q[3*g]) + PSUM_W'(prod_q[3*g+1]) +
                  PSUM_W'(prod_q[3*g+2]);
      pmin_d[g] = prod_q[3*g][PIX_W-1:0];
      pmax_d[g] = prod_q[3*g][PIX_W-1:0];
      for (int k = 1; k < 3; k++) begin
        if (prod_q[3*g+k][PIX_W-1:0] < pmin_d[g]) pmin_d[g] = prod_q[3*g+k][PIX_W-1:0];
        if (prod_q[3*g+k][PIX_W-1:0] > pmax_d[g]) pmax_d[g] = prod_q[3*g+k][PIX_W-1:0];
      end
    end
  end

  always_comb begin
    total = SUM_W'(psum_q[0]) + SUM_W'(psum_q[1]) + SUM_W'(psum_q[2]);
    quot  = total[SUM_W-1:3];
    mn    = pmin_q[0];
    mx    = pmax_q[0];
    for (int g = 1; g < 3; g++) begin
      if (pmin_q[g] < mn) mn = pmin_q[g];
      if (pmax_q[g] > mx) mx = pmax_q[g];
    end
    pixel_d = '0;
    if (b_act_q) begin
      case (mode_i)
        MODE_CONV: begin
          // a negative sum ends at zero whatever the rounding
          if (total[SUM_W-1]) begin
            pixel_d = '0;
          end else if (quot > (SUM_W-3)'(255)) begin
            pixel_d = 8'hff;
          end else begin
            pixel_d = quot[PIX_W-1:0];
          end
        end
        MODE_ERODE:  pixel_d = mn;
        MODE_DILATE: pixel_d = mx;
        default:     pixel_d = '0;
      endcase
    end
  end

  always_comb begin
    a_valid_d = win_accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_q);
    b_valid_d = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);
    c_valid_d = b_adv ? 1'b1 : (c_adv ? 1'b0 : c_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_accept) begin
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= prod_full[i][PROD_W-1:0];
      end
      a_side_q <= side_i;
      a_act_q  <= active_i;
    end
    if (a_adv) begin
      for (int g = 0; g < 3; g++) begin
        psum_q[g] <= psum_d[g];
        pmin_q[g] <= pmin_d[g];
        pmax_q[g] <= pmax_d[g];
      end
      b_side_q <= a_side_q;
      b_act_q  <= a_act_q;
    end
    if (b_adv) begin
      pixel_q  <= pixel_d;
      c_side_q <= b_side_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign pixel_o     = pixel_q;
  assign side_o      = c_side_q;

endmodule

`default_nettype wire

@@ dv/tb_window_3x3_conv_erode_dilate.sv @@
// self-checking testbench for the 3x3 convolution, erode and dilate window filter
`timescale 1ns / 1ps

module tb_window_3x3_conv_erode_dilate;
  import wced_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int CONV_DIV      = 8;
  localparam int PIX_MAX       = 255;
  localparam int DIRECTED_N    = 24;
  localparam int RANDOM_N      = 1826;
  localparam int PRESSURE_AT   = 1500;
  localparam int PRESSURE_HOLD = 400;
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef struct packed {
    pix_t  pixel;
    side_t side;
  } px_item_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_RARE,
    STALL_RUNS
  } stall_pattern_e;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           pixel_in_i = '0;
  logic                 keep_in_i  = 1'b0;
  logic                 strb_in_i  = 1'b0;
  logic [1:0]           user_in_i  = '0;
  logic                 last_in_i  = 1'b0;
  logic [5:0]           dest_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           pixel_out_o;
  logic                 keep_out_o;
  logic                 strb_out_o;
  logic [1:0]           user_out_o;
  logic                 last_out_o;
  logic [5:0]           dest_out_o;

  window_3x3_conv_erode_dilate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .keep_in_i   (keep_in_i),
    .strb_in_i   (strb_in_i),
    .user_in_i   (user_in_i),
    .last_in_i   (last_in_i),
    .dest_in_i   (dest_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .keep_out_o  (keep_out_o),
    .strb_out_o  (strb_out_o),
    .user_out_o  (user_out_o),
    .last_out_o  (last_out_o),
    .dest_out_o  (dest_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // filter state kept by the testbench
  pix_t    line_rows [3][IMAGE_WIDTH];
  int      row_pos     = 0;
  int      col_pos     = 0;
  kernel_t kern        = {3{KERNEL_RESET}};
  mode_e   filter_mode = MODE_CONV;

  px_item_t pixel_feed  [$];
  px_item_t expected_px [$];
  px_item_t cur_item;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int mismatches   = 0;
  int cycle_cnt    = 0;

  // sender and receiver idling controls
  int burst_max    = 1;
  int gap_max      = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int hold_left    = 0;
  bit pressure_done = 1'b0;
  int pattern_left = 0;
  stall_pattern_e stall_pattern = STALL_NONE;

  // shifts the column up one row, then forms the window ending at the new pixel
  function automatic pix_t filter_window(pix_t p);
    int               sum;
    int               prod;
    int               q;
    logic signed [7:0] cf;
    pix_t             lo;
    pix_t             mn;
    pix_t             mx;
    pix_t             res;
    sum = 0;
    mn  = 8'hFF;
    mx  = 8'h00;
    res = '0;
    line_rows[0][col_pos] = line_rows[1][col_pos];
    line_rows[1][col_pos] = line_rows[2][col_pos];
    line_rows[2][col_pos] = p;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cf   = kern[r][8*c +: 8];
          prod = int'(cf) * int'(line_rows[r][col_pos - 2 + c]);
          lo   = prod[7:0];
          sum += prod;
          if (lo < mn) mn = lo;
          if (lo > mx) mx = lo;
        end
      end
      case (filter_mode)
        MODE_CONV: begin
          q = sum / CONV_DIV;
          if (q < 0) q = 0;
          else if (q > PIX_MAX) q = PIX_MAX;
          res = pix_t'(q);
        end
        MODE_ERODE:  res = mn;
        MODE_DILATE: res = mx;
        default:     res = '0;
      endcase
    end
    if (col_pos < IMAGE_WIDTH - 1) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos >= IMAGE_HEIGHT - 1) row_pos = 0;
      else row_pos++;
    end
    return res;
  endfunction

  function automatic px_item_t rand_item();
    px_item_t it;
    case ($urandom_range(0, 7))
      0:       it.pixel = '0;
      1:       it.pixel = 8'hFF;
      default: it.pixel = pix_t'($urandom);
    endcase
    it.side = $bits(side_t)'($urandom);
    return it;
  endfunction

  function automatic krow_t rand_krow();
    krow_t kr;
    case ($urandom_range(0, 2))
      0: begin
        // small signed taps from -3 to 3
        for (int c = 0; c < 3; c++) kr[8*c +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
      end
      default: kr = krow_t'($urandom);
    endcase
    return kr;
  endfunction

  // extreme settings first, then random ones
  task automatic next_setting(input int k, output kernel_t kn, output mode_e md);
    kn[0] = rand_krow();
    kn[1] = rand_krow();
    kn[2] = rand_krow();
    md    = mode_e'($urandom_range(0, 3));
    case (k)
      0: begin kn = {3{24'h7F7F7F}}; md = MODE_CONV; end
      1: begin kn = {3{24'h808080}}; md = MODE_CONV; end
      2: begin kn = '0;              md = MODE_CONV; end
      3: begin kn = {3{24'hFFFFFF}}; md = MODE_CONV; end
      4: md = MODE_ERODE;
      5: md = MODE_DILATE;
      6: md = MODE_ZERO;
      7: begin kn = {24'h010101, 24'h808080, 24'h7F7F7F}; md = MODE_ERODE; end
      8: begin kn = {24'h7F7F7F, 24'h808080, 24'hFF00FF}; md = MODE_DILATE; end
      9: begin kn = {3{KERNEL_RESET}}; md = MODE_CONV; end
      default: ;
    endcase
  endtask

  // writes every register plus one unused index; op_mode gets junk upper bits
  task automatic load_setting(input kernel_t kn, input mode_e md);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_KERNEL_TOP;
    cfg_data_i <= kn[0];
    @(posedge clk_i);
    cfg_idx_i  <= REG_KERNEL_MID;
    cfg_data_i <= kn[1];
    @(posedge clk_i);
    cfg_idx_i  <= REG_KERNEL_BOTTOM;
    cfg_data_i <= kn[2];
    @(posedge clk_i);
    cfg_idx_i  <= REG_OP_MODE;
    cfg_data_i <= {(CFG_W - 2)'($urandom), md};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDX_W'($urandom_range(int'(REG_OP_MODE) + 1, (1 << CFG_IDX_W) - 1));
    cfg_data_i <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    kern        = kn;
    filter_mode = md;
  endtask

  task automatic queue_item(input px_item_t it);
    pixel_feed.push_back(it);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_px.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of items with gaps, payload held while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_px.push_back('{pixel: filter_window(cur_item.pixel), side: cur_item.side});
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          cur_item = pixel_feed.pop_front();
          pixel_in_i <= cur_item.pixel;
          keep_in_i  <= cur_item.side.keep;
          strb_in_i  <= cur_item.side.strb;
          user_in_i  <= cur_item.side.user;
          last_in_i  <= cur_item.side.last;
          dest_in_i  <= cur_item.side.dest;
          in_valid_i <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, burst_max);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall patterns of random length, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!pressure_done && accepted_cnt >= PRESSURE_AT && pixel_feed.size() > 0) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_HOLD;
      out_stall_i  <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_pattern = stall_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 256);
      end else begin
        pattern_left--;
      end
      case (stall_pattern)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_HALF: out_stall_i <= 1'($urandom_range(0, 1));
        STALL_RARE: out_stall_i <= ($urandom_range(0, 7) == 0);
        default:    out_stall_i <= (pattern_left % 6) < 4;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    px_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_px.size() == 0) begin
        $error("unexpected item: pixel_out %0d", pixel_out_o);
        mismatches++;
      end else begin
        want = expected_px.pop_front();
        check_field("pixel_out", want.pixel, pixel_out_o);
        check_field("keep_out", want.side.keep, keep_out_o);
        check_field("strb_out", want.side.strb, strb_out_o);
        check_field("user_out", want.side.user, user_out_o);
        check_field("last_out", want.side.last, last_out_o);
        check_field("dest_out", want.side.dest, dest_out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    px_item_t it;
    kernel_t  kn;
    mode_e    md;
    int       k;
    int       n;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting, pixel and sideband extremes across the border columns
    for (int i = 0; i < DIRECTED_N; i++) begin
      it.pixel     = (i % 3 == 2) ? pix_t'($urandom) : ((i % 2) ? 8'hFF : 8'h00);
      it.side.keep = i[0];
      it.side.strb = i[1];
      it.side.user = 2'(i % 4);
      it.side.last = i[2];
      it.side.dest = (i % 2) ? 6'h3F : 6'h00;
      queue_item(it);
    end
    wait_drained();

    // random phases, each under its own setting and idling
    k = 0;
    while (queued_cnt < DIRECTED_N + RANDOM_N) begin
      next_setting(k, kn, md);
      k++;
      load_setting(kn, md);
      burst_max = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase
      n = $urandom_range(80, 240);
      if (n > DIRECTED_N + RANDOM_N - queued_cnt) n = DIRECTED_N + RANDOM_N - queued_cnt;
      repeat (n) queue_item(rand_item());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ window_3x3_conv_erode_dilate.f @@
design/wced_pkg.sv
design/wced_ram.sv
design/wced_window.sv
design/wced_arith.sv
design/window_3x3_conv_erode_dilate.sv
dv/tb_window_3x3_conv_erode_dilate.sv
